### design/pih_pkg.sv
// Shared types and constants for the pixel intensity histogram.
package pih_pkg;

    localparam int PIXEL_BITS   = 8;
    localparam int PIXEL_LEVELS = 256;
    localparam int OUT_BITS     = 32;
    localparam int ACTION_BITS  = 2;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_ACCUM = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

endpackage

### design/pixel_intensity_histogram.sv
// Pixel intensity histogram with saturating bins and running peak count.
//
// Input stream s_axis: one item per handshake; s_axis_tuser selects the action
// (accumulate pixel, read bin, clear all bins), s_axis_tdata carries pixel
// value and bin select. Only a read item yields a result on m_axis, with the
// selected bin count and the peak count since the last clear.
// Bins sit in one synchronous memory read at acceptance; the count is updated
// and written back in the next cycle, with the last write forwarded when the
// next item hits the same bin. Throughput is one item per cycle unless a read
// item stalls; its result goes from the update stage to the output register.
// Reset clears the per-bin valid bits and the peak at once, so no clearing
// pass is needed; a clear item does the same.
// When the receiver stalls with a result waiting, a following read item holds
// in the update stage and s_axis_tready drops until the output register frees.
module pixel_intensity_histogram
    import pih_pkg::*;
#(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] pixel_value, [15:8] bin_select
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] bin_count, [63:32] max_count
);

    localparam int MEM_DEPTH = (NUM_BINS < PIXEL_LEVELS) ? NUM_BINS : PIXEL_LEVELS;
    localparam int IDX_W     = $clog2(MEM_DEPTH);

    logic [COUNT_BITS-1:0] bin_mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic [MEM_DEPTH-1:0]  bin_valid_reg;
    logic [COUNT_BITS-1:0] peak_reg;

    logic                  s1_valid_reg;
    logic [1:0]            s1_act_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic                  s1_hit_reg;

    logic                  fwd_valid_reg;
    logic [IDX_W-1:0]      fwd_idx_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic                  out_valid_reg;
    logic [63:0]           out_data_reg;

    logic                  in_accept;
    logic [1:0]            in_act;
    logic [PIXEL_BITS-1:0] in_val;
    logic [IDX_W-1:0]      in_idx;
    logic                  in_hit;

    logic                  s1_is_read;
    logic                  s1_fire;
    logic                  do_accum;
    logic                  do_clear;
    logic                  fwd_hit;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic [COUNT_BITS-1:0] bin_out;
    logic [OUT_BITS-1:0]   bin_clip;
    logic [OUT_BITS-1:0]   peak_clip;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_act    = s_axis_tuser;
    assign in_val    = (in_act == ACT_READ) ? s_axis_tdata[15:8] : s_axis_tdata[7:0];
    assign in_idx    = in_val[IDX_W-1:0];
    assign in_hit    = ({9'd0, in_val} < 17'(NUM_BINS));

    assign s1_is_read = (s1_act_reg == ACT_READ);
    assign s1_fire    = s1_valid_reg && (!s1_is_read || !out_valid_reg || m_axis_tready);
    assign do_accum   = s1_fire && (s1_act_reg == ACT_ACCUM) && s1_hit_reg;
    assign do_clear   = s1_fire && (s1_act_reg == ACT_CLEAR);

    assign s_axis_tready = !s1_valid_reg || s1_fire;

    assign fwd_hit   = fwd_valid_reg && (fwd_idx_reg == s1_idx_reg);
    assign cur_count = fwd_hit ? fwd_data_reg
                     : (bin_valid_reg[s1_idx_reg] ? rdata_reg : '0);
    assign inc_count = (&cur_count) ? cur_count : cur_count + 1'b1;
    assign bin_out   = s1_hit_reg ? cur_count : '0;

    generate
        if (COUNT_BITS > OUT_BITS) begin : g_clip
            assign bin_clip  = (|bin_out[COUNT_BITS-1:OUT_BITS]) ? '1
                             : bin_out[OUT_BITS-1:0];
            assign peak_clip = (|peak_reg[COUNT_BITS-1:OUT_BITS]) ? '1
                             : peak_reg[OUT_BITS-1:0];
        end else begin : g_ext
            assign bin_clip  = OUT_BITS'(bin_out);
            assign peak_clip = OUT_BITS'(peak_reg);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (do_accum)
        begin
            bin_mem[s1_idx_reg] <= inc_count;
        end
        if (in_accept)
        begin
            rdata_reg <= bin_mem[in_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_act_reg    <= ACT_ACCUM;
            s1_idx_reg    <= '0;
            s1_hit_reg    <= 1'b0;
            bin_valid_reg <= '0;
            peak_reg      <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_idx_reg   <= '0;
            fwd_data_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= in_accept;
                s1_act_reg   <= in_act;
                s1_idx_reg   <= in_idx;
                s1_hit_reg   <= in_hit;
            end
            if (do_clear)
            begin
                bin_valid_reg <= '0;
                peak_reg      <= '0;
            end
            else if (do_accum)
            begin
                bin_valid_reg[s1_idx_reg] <= 1'b1;
                if (inc_count > peak_reg)
                begin
                    peak_reg <= inc_count;
                end
            end
            if (s1_fire)
            begin
                fwd_valid_reg <= do_accum;
                fwd_idx_reg   <= s1_idx_reg;
                fwd_data_reg  <= inc_count;
            end
            if (s1_fire && s1_is_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_is_read)
        begin
            out_data_reg <= {peak_clip, bin_clip};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s1_fire && s1_is_read))
        else $error("result raised without a read item");

    a_clear_peak: assert property (@(posedge clk) disable iff (!rst_n)
        do_clear |=> (peak_reg == '0) && (bin_valid_reg == '0))
        else $error("clear did not empty the histogram");

    a_peak_covers_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> (peak_reg >= fwd_data_reg))
        else $error("peak below last written count");

    a_fwd_valid_bin: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> bin_valid_reg[fwd_idx_reg])
        else $error("forwarded bin not marked valid");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> s1_valid_reg && $stable(s1_idx_reg))
        else $error("stalled item lost from update stage");

endmodule
